// ===== sv/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// Operation codes and the command record passed from the front end to the
// back end of the scrollback line ring.
// ----------------------------------------------------------------------------
package slr_pkg;

	localparam logic [2:0] OP_LINE   = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_UP     = 3'd2;
	localparam logic [2:0] OP_DOWN   = 3'd3;
	localparam logic [2:0] OP_BOTTOM = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	// Command fields sized for the largest ring and line the block supports
	typedef logic [6:0] slot_f_t;
	typedef logic [5:0] pos_f_t;
	typedef logic [5:0] len_f_t;

	typedef struct packed {
		logic [5:0] visible;
		logic [5:0] count;
		logic [4:0] offset;
	} status_t;

	typedef struct packed {
		logic       is_read;
		logic       wr_text;
		logic       wr_len;
		logic       wr_attr;
		slot_f_t    slot;
		pos_f_t     pos;
		len_f_t     len;
		logic [7:0] text_byte;
		logic [15:0] attr;
		status_t    st;
	} cmd_t;

endpackage

// ===== sv/slr_front.sv =====
// ----------------------------------------------------------------------------
// slr_front
// Accepts items, keeps the ring pointers and the open-line fill state, and
// turns each item into one command for the back end.
// ----------------------------------------------------------------------------
module slr_front #(
	parameter int LINES      = 32,
	parameter int SLOT_BYTES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       operation,
	input  logic [7:0]       text_byte,
	input  logic             byte_present,
	input  logic             line_end,
	input  logic [15:0]      line_attr_in,
	input  logic [7:0]       row,
	input  logic             q_full,
	output logic             q_push,
	output slr_pkg::cmd_t    q_cmd
);

	localparam int SW  = $clog2(LINES);
	localparam int SLW = $clog2(LINES + 1);
	localparam int FPW = $clog2(SLOT_BYTES + 1);
	localparam int LW  = $clog2(SLOT_BYTES);
	localparam logic [FPW-1:0] CAP = FPW'(SLOT_BYTES - 1);

	logic [SW-1:0]  oldest_q, oldest_d;
	logic [SLW-1:0] stored_q, stored_d;
	logic [SW-1:0]  vb_q, vb_d;
	logic [SW-1:0]  fill_slot_q, fill_slot_d;
	logic [FPW-1:0] fp_q, fp_d, fp_cur;
	logic [LW-1:0]  cs_q, cs_d;
	logic           open_q, open_d;
	logic [7:0]     vr_q;

	logic              claim;
	logic [SLW:0]      sum_w;
	logic [SW-1:0]     append_slot;
	logic [7:0]        stored8, vb8, vis, vis_d;
	logic signed [9:0] logical;
	logic              row_ok;
	logic [8:0]        slot_sum;
	logic [SW-1:0]     read_slot;
	logic              accept;
	slr_pkg::cmd_t     cmd;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign q_push    = accept;
	assign q_cmd     = cmd;

	always_comb begin
		oldest_d    = oldest_q;
		stored_d    = stored_q;
		vb_d        = vb_q;
		fill_slot_d = fill_slot_q;
		fp_d        = fp_q;
		cs_d        = cs_q;
		open_d      = open_q;
		claim       = 1'b0;
		fp_cur      = fp_q;
		cmd         = '0;

		// slot that a new line takes while the ring still has room
		sum_w       = (SLW+1)'(oldest_q) + (SLW+1)'(stored_q);
		append_slot = (sum_w >= (SLW+1)'(LINES)) ? SW'(sum_w - (SLW+1)'(LINES)) : SW'(sum_w);

		// map a viewport row to a slot
		stored8  = 8'(stored_q);
		vb8      = 8'(vb_q);
		vis      = (stored8 < vr_q) ? stored8 : vr_q;
		logical  = $signed({2'b00, stored8}) - $signed({2'b00, vb8})
			- $signed({2'b00, vis}) + $signed({2'b00, row});
		row_ok   = (stored_q != '0) && (row < vis) && !logical[9]
			&& (logical < $signed({2'b00, stored8}));
		slot_sum = {1'b0, 8'(oldest_q)} + {1'b0, logical[7:0]};
		read_slot = (slot_sum >= 9'(LINES)) ? SW'(slot_sum - 9'(LINES)) : SW'(slot_sum);

		unique case (operation)
			slr_pkg::OP_LINE: begin
				if (!open_q) begin
					claim = 1'b1;
					if (stored_q < SLW'(LINES)) begin
						fill_slot_d = append_slot;
						stored_d    = stored_q + 1'b1;
					end else begin
						fill_slot_d = oldest_q;
						oldest_d    = (oldest_q == SW'(LINES - 1)) ? '0 : oldest_q + 1'b1;
					end
					fp_cur = '0;
					cs_d   = '0;
				end
				fp_d         = fp_cur;
				cmd.wr_len   = claim;
				cmd.wr_attr  = claim || line_end;
				if (byte_present && fp_cur <= CAP) begin
					cmd.wr_len = 1'b1;
					// a continuation byte stays with the character before it
					if (text_byte[7:6] != 2'b10)
						cs_d = LW'(fp_cur);
					if (fp_cur < CAP) begin
						cmd.wr_text = 1'b1;
						cmd.pos     = slr_pkg::pos_f_t'(fp_cur);
						fp_d        = fp_cur + 1'b1;
						cmd.len     = slr_pkg::len_f_t'(fp_cur + 1'b1);
					end else begin
						// overflow: roll back to the start of the cut character
						fp_d    = FPW'(SLOT_BYTES);
						cmd.len = slr_pkg::len_f_t'(cs_d);
					end
				end
				open_d   = !line_end;
				cmd.slot = slr_pkg::slot_f_t'(fill_slot_d);
			end
			slr_pkg::OP_READ: begin
				if (row_ok) begin
					cmd.is_read = 1'b1;
					cmd.slot    = slr_pkg::slot_f_t'(read_slot);
				end
			end
			slr_pkg::OP_UP: begin
				if ((SLW+1)'(vb_q) + 1'b1 < (SLW+1)'(stored_q))
					vb_d = vb_q + 1'b1;
			end
			slr_pkg::OP_DOWN: begin
				if (vb_q != '0)
					vb_d = vb_q - 1'b1;
			end
			slr_pkg::OP_BOTTOM: begin
				vb_d = '0;
			end
			slr_pkg::OP_CLEAR: begin
				oldest_d = '0;
				stored_d = '0;
				vb_d     = '0;
				open_d   = 1'b0;
			end
			default: begin
			end
		endcase

		cmd.text_byte  = text_byte;
		cmd.attr       = line_attr_in;
		vis_d          = (8'(stored_d) < vr_q) ? 8'(stored_d) : vr_q;
		cmd.st.visible = 6'(vis_d);
		cmd.st.count   = 6'(stored_d);
		cmd.st.offset  = 5'(vb_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			stored_q    <= '0;
			vb_q        <= '0;
			fill_slot_q <= '0;
			fp_q        <= '0;
			cs_q        <= '0;
			open_q      <= 1'b0;
			vr_q        <= 8'd24;
		end else begin
			if (cfg_valid && cfg_ready)
				vr_q <= cfg_data;
			if (accept) begin
				oldest_q    <= oldest_d;
				stored_q    <= stored_d;
				vb_q        <= vb_d;
				fill_slot_q <= fill_slot_d;
				fp_q        <= fp_d;
				cs_q        <= cs_d;
				open_q      <= open_d;
			end
		end
	end

	a_view_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vb_q == '0) || (SLW'(vb_q) < stored_q))
		else $error("view offset points past the stored lines");

	a_open_has_line: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (stored_q != '0))
		else $error("open line without a stored line");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= FPW'(SLOT_BYTES))
		else $error("fill position past the line size");

endmodule

// ===== sv/slr_fifo.sv =====
// ----------------------------------------------------------------------------
// slr_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module slr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output slr_pkg::cmd_t pop_cmd,
	output logic          empty
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	slr_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== sv/slr_back.sv =====
// ----------------------------------------------------------------------------
// slr_back
// Executes commands: writes the text, length and attribute stores, and
// streams status beats or the bytes of a read line through an output register.
// ----------------------------------------------------------------------------
module slr_back #(
	parameter int LINES      = 32,
	parameter int SLOT_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  slr_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          row_valid,
	output logic [15:0]   line_attr_out,
	output logic [7:0]    out_byte,
	output logic          out_byte_present,
	output logic          last,
	output logic [5:0]    visible_rows,
	output logic [5:0]    line_count,
	output logic [4:0]    scroll_offset
);

	localparam int SW = $clog2(LINES);
	localparam int LW = $clog2(SLOT_BYTES);
	localparam int AW = $clog2(LINES * SLOT_BYTES);

	localparam logic [1:0] B_IDLE   = 2'd0;
	localparam logic [1:0] B_META   = 2'd1;
	localparam logic [1:0] B_STREAM = 2'd2;

	logic [7:0]  text_mem [LINES * SLOT_BYTES];
	logic [LW-1:0] len_mem [LINES];
	logic [15:0] attr_mem [LINES];

	logic [1:0]       state_q, state_d;
	logic [SW-1:0]    slot_q;
	logic [LW-1:0]    idx_q;
	logic [LW-1:0]    len_rd_q;
	logic [15:0]      attr_rd_q;
	logic [7:0]       text_rd_q;
	slr_pkg::status_t st_q;

	logic          out_valid_q, row_valid_q, present_q, last_q;
	logic [15:0]   attr_q;
	logic [7:0]    byte_q;
	slr_pkg::status_t ost_q;

	logic          out_free, meta_rd, load_status, load_empty, start_stream;
	logic          load_byte, byte_last, text_rd;
	logic [SW-1:0] cmd_slot;
	logic [LW-1:0] rd_idx;
	logic [AW-1:0] wr_addr, rd_addr;

	assign out_free     = !out_valid_q || out_ready;
	assign q_pop        = (state_q == B_IDLE) && !q_empty && out_free;
	assign cmd_slot     = q_cmd.slot[SW-1:0];
	assign meta_rd      = q_pop && q_cmd.is_read;
	assign load_status  = q_pop && !q_cmd.is_read;
	assign load_empty   = (state_q == B_META) && (len_rd_q == '0) && out_free;
	assign start_stream = (state_q == B_META) && (len_rd_q != '0);
	assign load_byte    = (state_q == B_STREAM) && out_free;
	assign byte_last    = (idx_q == len_rd_q - LW'(1));
	assign text_rd      = start_stream || (load_byte && !byte_last);
	assign rd_idx       = start_stream ? '0 : idx_q + 1'b1;
	assign wr_addr      = AW'(cmd_slot) * AW'(SLOT_BYTES) + AW'(q_cmd.pos);
	assign rd_addr      = AW'(slot_q) * AW'(SLOT_BYTES) + AW'(rd_idx);

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.wr_text)
			text_mem[wr_addr] <= q_cmd.text_byte;
		if (text_rd)
			text_rd_q <= text_mem[rd_addr];
		if (q_pop && q_cmd.wr_len)
			len_mem[cmd_slot] <= q_cmd.len[LW-1:0];
		if (q_pop && q_cmd.wr_attr)
			attr_mem[cmd_slot] <= q_cmd.attr;
		if (meta_rd) begin
			len_rd_q  <= len_mem[cmd_slot];
			attr_rd_q <= attr_mem[cmd_slot];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (meta_rd)
					state_d = B_META;
			end
			B_META: begin
				if (load_empty)
					state_d = B_IDLE;
				else if (start_stream)
					state_d = B_STREAM;
			end
			B_STREAM: begin
				if (load_byte && byte_last)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			slot_q <= cmd_slot;
			st_q   <= q_cmd.st;
		end
		if (start_stream)
			idx_q <= '0;
		else if (load_byte && !byte_last)
			idx_q <= idx_q + 1'b1;
		if (load_status) begin
			row_valid_q <= 1'b0;
			attr_q      <= '0;
			byte_q      <= '0;
			present_q   <= 1'b0;
			last_q      <= 1'b1;
			ost_q       <= q_cmd.st;
		end else if (load_empty) begin
			row_valid_q <= 1'b1;
			attr_q      <= attr_rd_q;
			byte_q      <= '0;
			present_q   <= 1'b0;
			last_q      <= 1'b1;
			ost_q       <= st_q;
		end else if (load_byte) begin
			row_valid_q <= 1'b1;
			attr_q      <= attr_rd_q;
			byte_q      <= text_rd_q;
			present_q   <= 1'b1;
			last_q      <= byte_last;
			ost_q       <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_status || load_empty || load_byte)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign row_valid        = row_valid_q;
	assign line_attr_out    = attr_q;
	assign out_byte         = byte_q;
	assign out_byte_present = present_q;
	assign last             = last_q;
	assign visible_rows     = ost_q.visible;
	assign line_count       = ost_q.count;
	assign scroll_offset    = ost_q.offset;

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !row_valid_q) |-> last_q)
		else $error("status beat without last");

	a_idx_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_STREAM) |-> (idx_q < len_rd_q))
		else $error("byte index past line length");

	a_stream_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load_byte && byte_last) |=> (state_q == B_IDLE))
		else $error("stream did not end on its last byte");

endmodule

// ===== sv/scrollback_line_ring_top.sv =====
// A status beat passes the queue and output register; a valid read gives its first
// byte via queue, metadata read, text read and output register, an empty line its
// one beat without the text read, then one byte per cycle while out_ready holds.
// Items enter the 4-entry command queue one per cycle while it has room; the back
// end retires one command per cycle while out_ready holds, a read after its bytes.
// Reset: pointers, counts, queue and output clear at once; viewport_rows is 24.
// ----------------------------------------------------------------------------
// scrollback_line_ring_top
// Ring of text lines with per-line attributes, viewport scrolling and row
// reads. The front end owns all pointers and classifies each item into a
// command; the back end owns the line stores and drives the result beats.
// ----------------------------------------------------------------------------
module scrollback_line_ring_top #(
	parameter int LINES      = 32,
	parameter int SLOT_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// viewport_rows write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  text_byte,
	input  logic        byte_present,
	input  logic        line_end,
	input  logic [15:0] line_attr_in,
	input  logic [7:0]  row,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        row_valid,
	output logic [15:0] line_attr_out,
	output logic [7:0]  out_byte,
	output logic        out_byte_present,
	output logic        last,
	output logic [5:0]  visible_rows,
	output logic [5:0]  line_count,
	output logic [4:0]  scroll_offset
);

	// command path: front end -> queue -> back end
	slr_pkg::cmd_t push_cmd, pop_cmd;
	logic          q_push, q_full, q_pop, q_empty;

	// Front end: take a beat whenever the queue has room, advance the ring
	// pointers and fill state, and drop a command carrying the store writes
	// and the counts as they stand after the item.
	slr_front #(
		.LINES      (LINES),
		.SLOT_BYTES (SLOT_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.text_byte    (text_byte),
		.byte_present (byte_present),
		.line_end     (line_end),
		.line_attr_in (line_attr_in),
		.row          (row),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	// Queue: hold commands in order so store writes and reads keep item order
	slr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// Back end: apply writes, then emit one status beat or stream the line
	slr_back #(
		.LINES      (LINES),
		.SLOT_BYTES (SLOT_BYTES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_cmd            (pop_cmd),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.row_valid        (row_valid),
		.line_attr_out    (line_attr_out),
		.out_byte         (out_byte),
		.out_byte_present (out_byte_present),
		.last             (last),
		.visible_rows     (visible_rows),
		.line_count       (line_count),
		.scroll_offset    (scroll_offset)
	);

endmodule

// ===== dv/scrollback_line_ring_top_tb.sv =====
// ----------------------------------------------------------------------------
// scrollback_line_ring_top_tb
// Self-checking bench for the scrollback line ring. A queue of items feeds a
// clocked driver; a clocked monitor compares every result beat with the
// beats that an in-bench model of the ring predicts at item acceptance. The
// run walks through several viewport sizes and idle patterns on both sides.
// ----------------------------------------------------------------------------
module scrollback_line_ring_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINES      = 32;
	localparam int SLOT_BYTES = 64;
	localparam int LINE_CAP   = SLOT_BYTES - 1;
	localparam int PHASES     = 5;

	// Codes the block must ignore
	localparam logic [2:0] OP_RESERVED_6 = 3'd6;
	localparam logic [2:0] OP_RESERVED_7 = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  tbyte;
		logic        present;
		logic        endl;
		logic [15:0] attr;
		logic [7:0]  row;
	} ring_item_t;

	typedef struct packed {
		logic        row_ok;
		logic [15:0] attr;
		logic [7:0]  data;
		logic        present;
		logic        tail;
		logic [5:0]  visible;
		logic [5:0]  count;
		logic [4:0]  offset;
	} ring_beat_t;

	// ------------------------------------------------------------------------
	// DUT signals, all inputs at known values from time zero
	// ------------------------------------------------------------------------
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data     = 8'd0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [2:0]  operation    = slr_pkg::OP_LINE;
	logic [7:0]  text_byte    = 8'd0;
	logic        byte_present = 1'b0;
	logic        line_end     = 1'b0;
	logic [15:0] line_attr_in = 16'd0;
	logic [7:0]  row          = 8'd0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic        row_valid;
	logic [15:0] line_attr_out;
	logic [7:0]  out_byte;
	logic        out_byte_present;
	logic        beat_last;
	logic [5:0]  visible_rows;
	logic [5:0]  line_count;
	logic [4:0]  scroll_offset;

	scrollback_line_ring_top #(
		.LINES      (LINES),
		.SLOT_BYTES (SLOT_BYTES)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.text_byte        (text_byte),
		.byte_present     (byte_present),
		.line_end         (line_end),
		.line_attr_in     (line_attr_in),
		.row              (row),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.row_valid        (row_valid),
		.line_attr_out    (line_attr_out),
		.out_byte         (out_byte),
		.out_byte_present (out_byte_present),
		.last             (beat_last),
		.visible_rows     (visible_rows),
		.line_count       (line_count),
		.scroll_offset    (scroll_offset)
	);

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	ring_item_t  pending_items[$];   // items waiting for the driver
	ring_beat_t  awaited_beats[$];   // predicted result beats, oldest first
	ring_item_t  item_on_bus;
	logic [7:0]  draft_text[$];      // text of the next line to be queued
	int          queued_count   = 0;
	int          items_accepted = 0;
	int          mismatches     = 0;
	int          send_gap_pct   = 0;
	int          stall_pct      = 0;
	int          plan_lines     = 0; // rough line count seen by the generator

	// Ring model: line stores, pointers and the viewport register
	logic [7:0]  line_text [LINES*SLOT_BYTES];
	int          line_len  [LINES];
	logic [15:0] line_attr [LINES];
	int          head_slot     = 0;
	int          line_total    = 0;
	int          back_rows     = 0;
	int          open_slot     = 0;
	int          write_pos     = 0;
	int          glyph_start   = 0;
	logic        line_is_open  = 1'b0;
	int          viewport_model = 24;

	// Per-phase viewport size and idle percentages
	int viewport_plan [PHASES] = '{24, 255, 0, 5, 1};
	int gap_plan      [PHASES] = '{0, 67, 0, 7, 0};
	int stall_plan    [PHASES] = '{0, 0, 67, 7, 0};

	// ------------------------------------------------------------------------
	// Ring model
	// ------------------------------------------------------------------------
	function automatic int visible_now();
		return line_total < viewport_model ? line_total : viewport_model;
	endfunction

	// Append one beat, stamped with the counts as they stand now
	function automatic void expect_beat(logic ok, logic [15:0] a, logic [7:0] d,
	                                    logic pr, logic tl);
		ring_beat_t b;
		b.row_ok  = ok;
		b.attr    = a;
		b.data    = d;
		b.present = pr;
		b.tail    = tl;
		b.visible = 6'(visible_now());
		b.count   = 6'(line_total);
		b.offset  = 5'(back_rows);
		awaited_beats.push_back(b);
	endfunction

	// Take the next slot, evicting the oldest line once the ring is full
	function automatic void claim_slot(logic [15:0] a);
		if (line_total < LINES) begin
			open_slot = (head_slot + line_total) % LINES;
			line_total++;
		end else begin
			open_slot = head_slot;
			head_slot = (head_slot + 1) % LINES;
		end
		write_pos          = 0;
		glyph_start        = 0;
		line_len[open_slot]  = 0;
		line_attr[open_slot] = a;
		line_is_open       = 1'b1;
	endfunction

	// Store one byte; on overflow, cut back to the start of its character
	function automatic void append_byte(logic [7:0] b);
		if (write_pos > LINE_CAP)
			return;
		if (b[7:6] != 2'b10)
			glyph_start = write_pos;
		if (write_pos < LINE_CAP) begin
			line_text[open_slot*SLOT_BYTES + write_pos] = b;
			write_pos++;
			line_len[open_slot] = write_pos;
		end else begin
			write_pos = SLOT_BYTES;
			line_len[open_slot] = glyph_start;
		end
	endfunction

	// Map a viewport row to a slot and stream its bytes, or give status
	function automatic void read_row(int r);
		int vis;
		int logical;
		int slot;
		int len;
		vis = visible_now();
		if (line_total != 0 && r < vis) begin
			logical = line_total - back_rows - vis + r;
			if (logical >= 0 && logical < line_total) begin
				slot = (head_slot + logical) % LINES;
				len  = line_len[slot] > LINE_CAP ? LINE_CAP : line_len[slot];
				if (len == 0)
					expect_beat(1'b1, line_attr[slot], 8'h00, 1'b0, 1'b1);
				for (int i = 0; i < len; i++)
					expect_beat(1'b1, line_attr[slot], line_text[slot*SLOT_BYTES + i],
					            1'b1, i == len - 1);
				return;
			end
		end
		expect_beat(1'b0, 16'h0000, 8'h00, 1'b0, 1'b1);
	endfunction

	function automatic void predict_item(ring_item_t it);
		if (it.op == slr_pkg::OP_READ) begin
			read_row(int'(it.row));
		end else begin
			case (it.op)
				slr_pkg::OP_LINE: begin
					if (!line_is_open)
						claim_slot(it.attr);
					if (it.present)
						append_byte(it.tbyte);
					if (it.endl) begin
						line_attr[open_slot] = it.attr;
						line_is_open = 1'b0;
					end
				end
				slr_pkg::OP_UP: begin
					if (back_rows + 1 < line_total)
						back_rows++;
				end
				slr_pkg::OP_DOWN: begin
					if (back_rows > 0)
						back_rows--;
				end
				slr_pkg::OP_BOTTOM: back_rows = 0;
				slr_pkg::OP_CLEAR: begin
					head_slot    = 0;
					line_total   = 0;
					back_rows    = 0;
					line_is_open = 1'b0;
				end
				default: ;
			endcase
			expect_beat(1'b0, 16'h0000, 8'h00, 1'b0, 1'b1);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Item generation
	// ------------------------------------------------------------------------
	function automatic void post_item(logic [2:0] op, logic [7:0] tb, logic pr,
	                                  logic le, logic [15:0] at, logic [7:0] rw);
		pending_items.push_back({op, tb, pr, le, at, rw});
		queued_count++;
	endfunction

	// Fields that the operation ignores still toggle
	function automatic void post_random_fields(logic [2:0] op);
		post_item(op, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
		          8'($urandom));
		if (op == slr_pkg::OP_CLEAR)
			plan_lines = 0;
	endfunction

	// Mostly rows inside the visible window, now and then any row at all
	function automatic void queue_read_near();
		int vis;
		vis = plan_lines < viewport_model ? plan_lines : viewport_model;
		if (vis > 0 && $urandom_range(3) != 0)
			post_item(slr_pkg::OP_READ, 8'($urandom), 1'($urandom), 1'($urandom),
			          16'($urandom), 8'($urandom_range(vis - 1)));
		else
			post_random_fields(slr_pkg::OP_READ);
	endfunction

	// Fill the draft with UTF-8-like text: ASCII, 2/3/4-byte characters,
	// stray continuation bytes and arbitrary bytes
	function automatic void draft_random_text(int want);
		int kind;
		int tail_bytes;
		draft_text.delete();
		while (draft_text.size() < want) begin
			kind = $urandom_range(99);
			tail_bytes = 0;
			if (kind < 50) begin
				draft_text.push_back(8'($urandom_range(127)));
			end else if (kind < 65) begin
				draft_text.push_back(8'hc0 | 8'($urandom_range(31)));
				tail_bytes = 1;
			end else if (kind < 77) begin
				draft_text.push_back(8'he0 | 8'($urandom_range(15)));
				tail_bytes = 2;
			end else if (kind < 85) begin
				draft_text.push_back(8'hf0 | 8'($urandom_range(7)));
				tail_bytes = 3;
			end else if (kind < 93) begin
				draft_text.push_back(8'h80 | 8'($urandom_range(63)));
			end else begin
				draft_text.push_back(8'($urandom));
			end
			repeat (tail_bytes) draft_text.push_back(8'h80 | 8'($urandom_range(63)));
		end
	endfunction

	// Turn the draft into line items; a ragged line gets byte-less items,
	// reads between its bytes and sometimes a separate closing item
	function automatic void queue_draft_line(logic ragged);
		logic split_end;
		if (draft_text.size() == 0) begin
			post_item(slr_pkg::OP_LINE, 8'($urandom), 1'b0, 1'b1, 16'($urandom),
			          8'($urandom));
		end else begin
			split_end = ragged && ($urandom_range(4) == 0);
			foreach (draft_text[i]) begin
				if (ragged && $urandom_range(99) < 8)
					post_item(slr_pkg::OP_LINE, 8'($urandom), 1'b0, 1'b0, 16'($urandom),
					          8'($urandom));
				if (ragged && $urandom_range(99) < 4)
					queue_read_near();
				post_item(slr_pkg::OP_LINE, draft_text[i], 1'b1,
				          !split_end && (i == draft_text.size() - 1),
				          16'($urandom), 8'($urandom));
			end
			if (split_end)
				post_item(slr_pkg::OP_LINE, 8'($urandom), 1'b0, 1'b1, 16'($urandom),
				          8'($urandom));
		end
		if (plan_lines < LINES)
			plan_lines++;
	endfunction

	// Random mix: mostly whole lines and reads, then scrolling and noise
	function automatic void queue_random(int budget);
		int start;
		int pick;
		int n;
		start = queued_count;
		while (queued_count - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				n = $urandom_range(99);
				if (n < 10)      n = 0;
				else if (n < 80) n = $urandom_range(6, 1);
				else if (n < 95) n = $urandom_range(20, 7);
				else             n = $urandom_range(75, 58);
				draft_random_text(n);
				queue_draft_line(1'b1);
			end else if (pick < 72) begin
				queue_read_near();
			end else if (pick < 82) begin
				repeat ($urandom_range(8, 1)) post_random_fields(slr_pkg::OP_UP);
			end else if (pick < 87) begin
				post_random_fields(slr_pkg::OP_DOWN);
			end else if (pick < 90) begin
				post_random_fields(slr_pkg::OP_BOTTOM);
			end else if (pick < 92) begin
				post_random_fields(slr_pkg::OP_CLEAR);
			end else begin
				// noise: any code, including stray line items and reserved codes
				post_random_fields(3'($urandom_range(7)));
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Clock, timeout
	// ------------------------------------------------------------------------
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("scrollback_line_ring_top_tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: present one item per beat, hold it until accepted, and run the
	// model on the item at the edge that accepts it
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_item(item_on_bus);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					item_on_bus = pending_items.pop_front();
					{operation, text_byte, byte_present, line_end, line_attr_in, row}
						<= item_on_bus;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each accepted beat with the oldest prediction, then
	// pick the ready level for the next edge
	// ------------------------------------------------------------------------
	function automatic string beat_text(ring_beat_t b);
		return $sformatf({"row_valid=%0d attr=%h byte=%h present=%0d last=%0d ",
		                  "visible=%0d count=%0d offset=%0d"},
		                 b.row_ok, b.attr, b.data, b.present, b.tail,
		                 b.visible, b.count, b.offset);
	endfunction

	always @(posedge clk) begin
		ring_beat_t seen;
		ring_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {row_valid, line_attr_out, out_byte, out_byte_present, beat_last,
			        visible_rows, line_count, scroll_offset};
			if (awaited_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %s", beat_text(seen));
			end else begin
				want = awaited_beats.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("beat mismatch");
						$display("  expected %s", beat_text(want));
						$display("  actual   %s", beat_text(seen));
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ------------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------------

	// Hold until every queued item is in and every predicted beat is out
	task automatic wait_drained();
		do @(posedge clk);
		while (items_accepted != queued_count || awaited_beats.size() != 0);
	endtask

	// Write the viewport size; only called while the ring is idle
	task automatic write_viewport(logic [7:0] rows);
		cfg_data  <= rows;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		viewport_model = int'(rows);
	endtask

	initial begin
		int p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (p = 0; p < PHASES; p++) begin
			// Each phase starts from an idle ring: the sender has paused until
			// every predicted beat came back, so the register may change now
			if (p != 0)
				write_viewport(8'(viewport_plan[p]));
			send_gap_pct = gap_plan[p];
			stall_pct    = stall_plan[p];
			plan_lines   = line_total;

			case (p)
				0: begin
					// empty ring: read, scroll both ways, jump to bottom
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd0);
					post_random_fields(slr_pkg::OP_UP);
					post_random_fields(slr_pkg::OP_DOWN);
					post_random_fields(slr_pkg::OP_BOTTOM);
					// empty line: one item without a byte that also ends it
					post_item(slr_pkg::OP_LINE, 8'hff, 1'b0, 1'b1, 16'hffff, 8'hff);
					// NUL, 0xFF, a stray continuation, a byte-less item, then a
					// two-byte character split by a read of the still-open line
					post_item(slr_pkg::OP_LINE, 8'h00, 1'b1, 1'b0, 16'h1234, 8'h00);
					post_item(slr_pkg::OP_LINE, 8'hff, 1'b1, 1'b0, 16'hffff, 8'h00);
					post_item(slr_pkg::OP_LINE, 8'h80, 1'b1, 1'b0, 16'h5555, 8'h00);
					post_item(slr_pkg::OP_LINE, 8'h55, 1'b0, 1'b0, 16'haaaa, 8'h00);
					post_item(slr_pkg::OP_LINE, 8'hc3, 1'b1, 1'b0, 16'h0001, 8'h00);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd1);
					// closing attribute replaces the one taken at the claim
					post_item(slr_pkg::OP_LINE, 8'ha9, 1'b1, 1'b1, 16'h0000, 8'h00);
					// both rows, one just past the visible rows, the top code
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd0);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd1);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd2);
					post_item(slr_pkg::OP_READ, 8'hff, 1'b1, 1'b1, 16'hffff, 8'd255);
					// scroll up once, then again at the bound; row 0 now maps
					// before the oldest line
					post_random_fields(slr_pkg::OP_UP);
					post_random_fields(slr_pkg::OP_UP);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd0);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd1);
					post_random_fields(slr_pkg::OP_DOWN);
					post_random_fields(slr_pkg::OP_BOTTOM);
					// reserved codes, then clear and read the emptied ring
					post_random_fields(OP_RESERVED_6);
					post_random_fields(OP_RESERVED_7);
					post_random_fields(slr_pkg::OP_CLEAR);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 8'd0);
				end
				1: begin
					// three-byte character straddling the cap: drop it and the rest
					draft_text.delete();
					repeat (LINE_CAP - 1) draft_text.push_back(8'h61);
					draft_text.push_back(8'he2);
					draft_text.push_back(8'h82);
					draft_text.push_back(8'hac);
					repeat (3) draft_text.push_back(8'h7a);
					queue_draft_line(1'b0);
					post_random_fields(slr_pkg::OP_BOTTOM);
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000,
					          8'(plan_lines - 1));
					post_item(slr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000,
					          8'(plan_lines - 2));
				end
				3: begin
					// run of short lines to wrap the ring and evict the oldest
					repeat (LINES + 1) begin
						draft_random_text($urandom_range(1));
						queue_draft_line(1'b0);
					end
					repeat (4) queue_read_near();
				end
				default: ;
			endcase

			queue_random(4);
			wait_drained();
		end

		// Let any stray beat show up before judging
		repeat (20) @(posedge clk);
		if (mismatches == 0 && awaited_beats.size() == 0)
			$display("scrollback_line_ring_top_tb OK");
		else
			$display("scrollback_line_ring_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
sv/slr_pkg.sv
sv/slr_front.sv
sv/slr_fifo.sv
sv/slr_back.sv
sv/scrollback_line_ring_top.sv
dv/scrollback_line_ring_top_tb.sv
